[src/mexp_pkg.sv]
package mexp_pkg;

  localparam int BASE_W = 30;
  localparam int EXP_W  = 63;
  localparam int RES_W  = 30;

  localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;

  // Barrett reduction constant: floor(2^60 / MODULUS), which fits in 31 bits.
  localparam logic [63:0] BARRETT_MU_FULL = 64'h1000_0000_0000_0000 / 64'(MODULUS);
  localparam int          MU_W            = 31;
  localparam logic [MU_W-1:0] BARRETT_MU  = BARRETT_MU_FULL[MU_W-1:0];

  // Destination of a modular product.
  localparam logic TAG_ACC = 1'b0;
  localparam logic TAG_SQR = 1'b1;

  typedef struct packed {
    logic load;
    logic issue_mul;
    logic issue_sqr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic sqr_done;
    logic out_free;
  } status_t;

endpackage

[src/mexp_if.sv]
interface mexp_in_if;
  import mexp_pkg::*;

  logic               valid;
  logic               ready;
  logic [BASE_W-1:0]  base_value;
  logic [EXP_W-1:0]   exponent_value;

  modport source (output valid, output base_value, output exponent_value, input ready);
  modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic              valid;
  logic              ready;
  logic [RES_W-1:0]  power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

[src/mexp_modmul.sv]
module mexp_modmul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      op_valid,
  input  logic                      op_tag,
  input  logic [mexp_pkg::RES_W-1:0] op_a,
  input  logic [mexp_pkg::RES_W-1:0] op_b,
  output logic                      res_valid,
  output logic                      res_tag,
  output logic [mexp_pkg::RES_W-1:0] res_value
);
  import mexp_pkg::*;

  localparam int PROD_W = 2 * RES_W;
  localparam int Q_W    = MU_W;
  localparam int QM_W   = Q_W + MU_W;
  localparam int LOW_W  = RES_W + 2;

  logic [3:0]            valid_r;
  logic [3:0]            tag_r;

  logic [PROD_W-1:0]     prod_r;
  logic [QM_W-1:0]       qm_r;
  logic [LOW_W-1:0]      plo2_r;
  logic [LOW_W-1:0]      plo3_r;
  logic [LOW_W-1:0]      qp_r;
  logic [RES_W-1:0]      res_r;

  logic [Q_W-1:0]        q1;
  logic [Q_W-1:0]        q3;
  logic [Q_W+RES_W-1:0]  qp_full;
  logic [LOW_W-1:0]      rem;
  logic [LOW_W-1:0]      rem_m1;
  logic [LOW_W-1:0]      rem_m2;
  logic [LOW_W-1:0]      mod_1x;
  logic [LOW_W-1:0]      mod_2x;
  logic [RES_W-1:0]      res_nxt;

  assign q1      = prod_r[PROD_W-1:RES_W-1];
  assign q3      = qm_r[QM_W-1:RES_W+1];
  assign qp_full = q3 * MODULUS;

  // The quotient estimate is at most two below the true one, so the
  // remainder stays below 3 * MODULUS and fits in the low word.
  assign mod_1x = LOW_W'(MODULUS);
  assign mod_2x = {1'b0, MODULUS, 1'b0};
  assign rem    = plo3_r - qp_r;
  assign rem_m1 = rem - mod_1x;
  assign rem_m2 = rem - mod_2x;

  always_comb begin
    if (rem >= mod_2x) begin
      res_nxt = rem_m2[RES_W-1:0];
    end else if (rem >= mod_1x) begin
      res_nxt = rem_m1[RES_W-1:0];
    end else begin
      res_nxt = rem[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], op_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= {tag_r[2:0], op_tag};
    prod_r <= op_a * op_b;
    qm_r   <= q1 * BARRETT_MU;
    plo2_r <= prod_r[LOW_W-1:0];
    plo3_r <= plo2_r;
    qp_r   <= qp_full[LOW_W-1:0];
    res_r  <= res_nxt;
  end

  assign res_valid = valid_r[3];
  assign res_tag   = tag_r[3];
  assign res_value = res_r;

endmodule

[src/mexp_ctrl.sv]
module mexp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mexp_pkg::status_t status,
  output mexp_pkg::cmd_t    cmd
);
  import mexp_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BIT  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        if (status.exp_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.issue_mul = status.exp_lsb;
          state_nxt     = ST_SQR;
        end
      end
      ST_SQR: begin
        cmd.issue_sqr = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        // The square is issued in the cycle after the multiply and trails it through
        // the multiplier, so both writebacks are done once it lands.
        if (status.sqr_done) begin
          state_nxt = ST_BIT;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[src/mexp_datapath.sv]
module mexp_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mexp_pkg::cmd_t             cmd,
  output mexp_pkg::status_t          status,
  input  logic [mexp_pkg::BASE_W-1:0] base_value,
  input  logic [mexp_pkg::EXP_W-1:0]  exponent_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mexp_pkg::RES_W-1:0]  power_result
);
  import mexp_pkg::*;

  logic [RES_W-1:0] sq_r;
  logic [RES_W-1:0] acc_r;
  logic [EXP_W-1:0] exp_r;
  logic [RES_W-1:0] out_result_r;
  logic             out_valid_r;
  logic             out_valid_nxt;

  logic [RES_W-1:0] base_reduced;
  logic [RES_W-1:0] op_a;
  logic             mm_op_valid;
  logic             mm_res_valid;
  logic             mm_res_tag;
  logic [RES_W-1:0] mm_res_value;

  // The base is below 2^30, which is less than twice the modulus.
  assign base_reduced = (base_value >= MODULUS) ? (base_value - MODULUS) : base_value;

  assign op_a        = cmd.issue_sqr ? sq_r : acc_r;
  assign mm_op_valid = cmd.issue_mul | cmd.issue_sqr;

  mexp_modmul u_modmul (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (mm_op_valid),
    .op_tag    (cmd.issue_sqr ? TAG_SQR : TAG_ACC),
    .op_a      (op_a),
    .op_b      (sq_r),
    .res_valid (mm_res_valid),
    .res_tag   (mm_res_tag),
    .res_value (mm_res_value)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_r  <= base_reduced;
      acc_r <= RES_W'(1);
      exp_r <= exponent_value;
    end else begin
      if (cmd.issue_sqr) begin
        exp_r <= exp_r >> 1;
      end
      if (mm_res_valid && (mm_res_tag == TAG_SQR)) begin
        sq_r <= mm_res_value;
      end
      if (mm_res_valid && (mm_res_tag == TAG_ACC)) begin
        acc_r <= mm_res_value;
      end
    end
    if (cmd.out_load) begin
      out_result_r <= acc_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.exp_zero = (exp_r == '0);
  assign status.exp_lsb  = exp_r[0];
  assign status.sqr_done = mm_res_valid && (mm_res_tag == TAG_SQR);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign power_result = out_result_r;

endmodule

[src/modular_exponentiation_top.sv]
// The controller steps through the exponent bits, from the lowest up to the highest
// set bit (none for a zero exponent, up to 63); each bit waits for the square to
// pass through the four-stage Barrett modular multiplier. A new request is taken
// only once the result of the last one is loaded into the output register.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous and active low; it clears control state only.
module modular_exponentiation_top (
  input logic        clk,
  input logic        rst_n,
  mexp_in_if.sink    in_chan,
  mexp_out_if.source out_chan
);
  import mexp_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_chan.ready = in_ready;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .base_value     (in_chan.base_value),
    .exponent_value (in_chan.exponent_value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .power_result   (out_chan.power_result)
  );

endmodule

[src/mexp_checker.sv]
module mexp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [mexp_pkg::EXP_W-1:0]  in_exponent,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mexp_pkg::RES_W-1:0]  out_result
);
  import mexp_pkg::*;

  // Only one request is in flight, so the port closes right after taking one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on the cycle after a request was accepted");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result < MODULUS))
    else $error("result is not reduced below the modulus");

  // A zero exponent skips the multiplier and returns one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_exponent == '0) && !out_valid)
      |-> ##3 (out_valid && (out_result == RES_W'(1))))
    else $error("zero exponent did not give one on time");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_result))
    else $error("result changed while stalled");

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_exponent (in_chan.exponent_value),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_result  (out_chan.power_result)
);
